// ----- src/ppa_pkg.sv -----
// shared constants, types and helpers for the progressive pixel accumulator
// no dependencies; every other file imports this package
package ppa_pkg;

	localparam int PIXELS      = 1024;
	localparam int STORE_DEPTH = 4 * PIXELS;
	localparam int IDX_W       = 12;
	localparam int MEM_DEPTH   = (STORE_DEPTH < (1 << IDX_W)) ? STORE_DEPTH : (1 << IDX_W);
	localparam int ADDR_W      = $clog2(MEM_DEPTH);

	localparam int SAMPLE_W = 16;
	localparam int FRAC_W   = 16;
	localparam int ACC_W    = 32;
	localparam int INV_W    = 17;
	localparam int AGE_W    = 16;
	localparam int DIV_W    = AGE_W + 1;
	localparam int PROD_W   = ACC_W + INV_W;
	localparam int SCALE_W  = PROD_W - FRAC_W;
	localparam int CMP_W    = INV_W + 3;

	localparam int INV_AGE_RESET  = 65536;
	localparam int FIRST_PASS_LIM = 3 * 65536;
	localparam int ROUND_HALF     = 1 << (FRAC_W - 1);
	localparam int ERR_THRESHOLD  = 32;
	localparam int RES_BIAS       = 3;

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int OCC_W      = FIFO_AW + 1;
	localparam int STAGES     = 4;
	localparam int BUSY_W     = $clog2(STAGES + 1);

	typedef enum logic {
		REG_INV_AGE  = 1'b0,
		REG_PASS_AGE = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [ACC_W-1:0] accumulated;
		logic [ACC_W-1:0] residual;
		logic             residual_valid;
	} result_t;

	typedef struct packed {
		logic [BUSY_W-1:0] busy_cnt;
		logic              last_pend;
	} pipe_stat_t;

	typedef struct packed {
		logic             valid;
		logic             last;
		logic [ACC_W-1:0] acc;
		logic [ACC_W-1:0] total;
	} pipe_out_t;

	function automatic logic [ACC_W-1:0] sat_add32(input logic [ACC_W-1:0] a,
		input logic [ACC_W-1:0] b);
		logic [ACC_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
	endfunction

endpackage

// ----- src/ppa_store.sv -----
// accumulation store: one write port, one read port, registered read data
// depends on ppa_pkg
module ppa_store import ppa_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [ACC_W-1:0]  wr_data,
	input  logic              re,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [ACC_W-1:0]  rd_data
);

	logic [ACC_W-1:0] mem [MEM_DEPTH];
	logic [ACC_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[wr_addr] <= wr_data;
		if (re)
			rd_q <= mem[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

// ----- src/ppa_div.sv -----
// restoring divider for the residual, one quotient bit per cycle
// depends on ppa_pkg
module ppa_div import ppa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [ACC_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [ACC_W-1:0] quotient
);

	localparam int STEP_W = $clog2(ACC_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [ACC_W-1:0]  quo_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  dsr_q;

	logic [DIV_W:0] rem_sh;
	logic [DIV_W:0] diff;
	logic           ge;

	// remainder stays below divisor, so the shifted value is below twice the divisor
	assign rem_sh = {rem_q, quo_q[ACC_W-1]};
	assign ge     = rem_sh >= {1'b0, dsr_q};
	assign diff   = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= !start && busy_q && (step_q == STEP_W'(ACC_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(ACC_W - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
			quo_q <= {quo_q[ACC_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- src/ppa_pipe.sv -----
// read-modify-write pipeline: store update, error estimate, residual sum
// depends on ppa_pkg; drives the ports of ppa_store
module ppa_pipe import ppa_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [IDX_W-1:0]    entry_index,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic                last,
	input  logic [INV_W-1:0]    inverse_age,
	output logic                rd_en,
	output logic [ADDR_W-1:0]   rd_addr,
	input  logic [ACC_W-1:0]    rd_data,
	output logic                wr_en,
	output logic [ADDR_W-1:0]   wr_addr,
	output logic [ACC_W-1:0]    wr_data,
	output pipe_out_t           res,
	output pipe_stat_t          stat
);

	logic in_range;

	// stage 1: read data back
	logic                v_s1, last_s1, inr_s1;
	logic [ADDR_W-1:0]   idx_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	// stage 2: multiply
	logic                v_s2, last_s2, inr_s2, first_s2;
	logic [ACC_W-1:0]    acc_s2, err1_s2;
	logic [SAMPLE_W-1:0] sample_s2;
	// stage 3: error
	logic                v_s3, last_s3, inr_s3, first_s3;
	logic [ACC_W-1:0]    acc_s3, err1_s3;
	logic [SAMPLE_W-1:0] sample_s3;
	logic [PROD_W-1:0]   prod_s3;
	// stage 4: residual sum
	logic                v_s4, last_s4;
	logic [ACC_W-1:0]    acc_s4, err_s4;

	logic                fwd_v_q;
	logic [ADDR_W-1:0]   fwd_addr_q;
	logic [ACC_W-1:0]    fwd_data_q;
	logic [ACC_W-1:0]    resid_q;

	logic [ACC_W-1:0]    old, smp1, acc1, err1;
	logic [CMP_W-1:0]    inv_x5;
	logic                first;
	logic [PROD_W-1:0]   rounded;
	logic [SCALE_W-1:0]  scaled, smp3, err2;
	logic [ACC_W-1:0]    err2c, err;
	logic                hit;
	logic [ACC_W-1:0]    sum_next;

	assign in_range = int'(entry_index) < STORE_DEPTH;
	assign rd_en    = accept & in_range;
	assign rd_addr  = entry_index[ADDR_W-1:0];

	// the previous item's write lands on the same edge as this item's read
	assign old    = (fwd_v_q && fwd_addr_q == idx_s1) ? fwd_data_q : rd_data;
	assign smp1   = ACC_W'(sample_s1);
	assign inv_x5 = {3'b0, inverse_age} + {1'b0, inverse_age, 2'b0};
	assign first  = inv_x5 > CMP_W'(FIRST_PASS_LIM);
	assign err1   = (old > smp1) ? old - smp1 : smp1 - old;

	always_comb begin
		if (!inr_s1)
			acc1 = '0;
		else if (first)
			acc1 = smp1;
		else
			acc1 = sat_add32(old, smp1);
	end

	assign wr_en   = v_s1 & inr_s1;
	assign wr_addr = idx_s1;
	assign wr_data = acc1;

	assign rounded = prod_s3 + PROD_W'(ROUND_HALF);
	assign scaled  = rounded[PROD_W-1:FRAC_W];
	assign smp3    = SCALE_W'(sample_s3);
	assign err2    = (scaled > smp3) ? scaled - smp3 : smp3 - scaled;
	assign err2c   = (|err2[SCALE_W-1:ACC_W]) ? {ACC_W{1'b1}} : err2[ACC_W-1:0];
	assign err     = first_s3 ? err1_s3 : err2c;
	assign hit     = inr_s3 && (err > ACC_W'(ERR_THRESHOLD));

	assign sum_next = sat_add32(resid_q, err_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			fwd_v_q <= 1'b0;
			resid_q <= '0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (wr_en)
				fwd_v_q <= 1'b1;
			if (v_s4)
				resid_q <= last_s4 ? '0 : sum_next;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1    <= entry_index[ADDR_W-1:0];
		sample_s1 <= sample;
		last_s1   <= last;
		inr_s1    <= in_range;

		last_s2   <= last_s1;
		inr_s2    <= inr_s1;
		first_s2  <= first;
		acc_s2    <= acc1;
		err1_s2   <= err1;
		sample_s2 <= sample_s1;

		last_s3   <= last_s2;
		inr_s3    <= inr_s2;
		first_s3  <= first_s2;
		acc_s3    <= acc_s2;
		err1_s3   <= err1_s2;
		sample_s3 <= sample_s2;
		prod_s3   <= PROD_W'(acc_s2) * PROD_W'(inverse_age);

		last_s4   <= last_s3;
		acc_s4    <= acc_s3;
		err_s4    <= hit ? err : '0;

		if (wr_en) begin
			fwd_addr_q <= idx_s1;
			fwd_data_q <= acc1;
		end
	end

	assign res.valid = v_s4;
	assign res.last  = last_s4;
	assign res.acc   = acc_s4;
	assign res.total = sum_next;

	assign stat.busy_cnt = BUSY_W'(v_s1) + BUSY_W'(v_s2) + BUSY_W'(v_s3) + BUSY_W'(v_s4);
	assign stat.last_pend = (v_s1 & last_s1) | (v_s2 & last_s2) | (v_s3 & last_s3)
		| (v_s4 & last_s4);

endmodule

// ----- src/progressive_pixel_accumulator.sv -----
// path: an ordinary item goes from accept through the store read-modify-write pipeline to the result
// queue; an item marked last also passes through the one-bit-per-cycle residual divider
// throughput: one item per cycle through the store read-modify-write pipeline while the result
// queue has room; a last item holds off input until its divided residual is queued
// reset: the store is zeroed by a sweep over all 4096 entries, one entry per cycle, while
// sample_stall stays high; configuration writes are taken during the sweep
module progressive_pixel_accumulator import ppa_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [INV_W-1:0]    cfg_data,
	input  logic                sample_valid,
	output logic                sample_stall,
	input  logic [IDX_W-1:0]    entry_index,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic                last,
	output logic                result_valid,
	input  logic                result_stall,
	output logic [ACC_W-1:0]    accumulated,
	output logic [ACC_W-1:0]    residual,
	output logic                residual_valid
);

	logic [INV_W-1:0]  inv_age_q;
	logic [AGE_W-1:0]  pass_age_q;
	logic              clr_q;
	logic [ADDR_W-1:0] clr_addr_q;

	logic              accept;
	pipe_out_t         pres;
	pipe_stat_t        pstat;

	logic              rd_en, pwr_en, st_we;
	logic [ADDR_W-1:0] rd_addr, pwr_addr, st_addr;
	logic [ACC_W-1:0]  rd_data, pwr_data, st_data;

	logic              div_start, div_busy, div_done;
	logic [ACC_W-1:0]  quotient;
	logic [ACC_W-1:0]  last_acc_q;

	result_t           fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [OCC_W-1:0]  fifo_cnt_q;
	logic              push_item, push, pop;
	result_t           push_data, head;
	logic [OCC_W-1:0]  occ;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_age_q  <= INV_W'(INV_AGE_RESET);
			pass_age_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_INV_AGE:  inv_age_q  <= cfg_data;
				REG_PASS_AGE: pass_age_q <= cfg_data[AGE_W-1:0];
				default: ;
			endcase
		end
	end

	// store clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_W'(MEM_DEPTH - 1))
				clr_q <= 1'b0;
		end
	end

	// items in flight anywhere count against the result queue
	assign occ = OCC_W'(pstat.busy_cnt) + OCC_W'(div_busy | div_done) + fifo_cnt_q;
	assign sample_stall = clr_q | pstat.last_pend | div_busy | (occ >= OCC_W'(FIFO_DEPTH));
	assign accept = sample_valid & ~sample_stall;

	ppa_pipe u_pipe (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.entry_index (entry_index),
		.sample      (sample),
		.last        (last),
		.inverse_age (inv_age_q),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.wr_en       (pwr_en),
		.wr_addr     (pwr_addr),
		.wr_data     (pwr_data),
		.res         (pres),
		.stat        (pstat)
	);

	assign st_we   = clr_q | pwr_en;
	assign st_addr = clr_q ? clr_addr_q : pwr_addr;
	assign st_data = clr_q ? '0 : pwr_data;

	ppa_store u_store (
		.clk     (clk),
		.we      (st_we),
		.wr_addr (st_addr),
		.wr_data (st_data),
		.re      (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign div_start = pres.valid & pres.last;

	ppa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (pres.total),
		.divisor  (DIV_W'(pass_age_q) + DIV_W'(RES_BIAS)),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk) begin
		if (div_start)
			last_acc_q <= pres.acc;
	end

	// result queue
	assign push_item = pres.valid & ~pres.last;
	assign push      = push_item | div_done;
	assign pop       = result_valid & ~result_stall;

	always_comb begin
		if (div_done) begin
			push_data.accumulated    = last_acc_q;
			push_data.residual       = quotient;
			push_data.residual_valid = 1'b1;
		end else begin
			push_data.accumulated    = pres.acc;
			push_data.residual       = '0;
			push_data.residual_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				fifo_cnt_q <= fifo_cnt_q + 1'b1;
			else if (pop && !push)
				fifo_cnt_q <= fifo_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= push_data;
	end

	assign head           = fifo_q[rd_ptr_q];
	assign result_valid   = fifo_cnt_q != '0;
	assign accumulated    = head.accumulated;
	assign residual       = head.residual;
	assign residual_valid = head.residual_valid;

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !clr_q)
		else $error("item accepted during store clearing");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q <= OCC_W'(FIFO_DEPTH))
		else $error("result queue overflow");

	a_single_push: assert property (@(posedge clk) disable iff (!arst_n)
		!(push_item && div_done))
		else $error("two results pushed in one cycle");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy && !div_done)
		else $error("divider started while occupied");

endmodule

// ----- dv/progressive_pixel_accumulator_test.sv -----
`timescale 1ns / 100ps
// self-checking testbench for the progressive pixel accumulator
// depends on ppa_pkg and progressive_pixel_accumulator from the rtl
module progressive_pixel_accumulator_test;
	import ppa_pkg::*;

	localparam int RANDOM_ITEMS = 1730;
	localparam int IDLE_PCT     = 14;
	localparam int SETTLE_CYCLES = 60;

	typedef struct packed {
		logic [IDX_W-1:0]    idx;
		logic [SAMPLE_W-1:0] smp;
		logic                lst;
	} sample_item_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic                cfg_index = REG_INV_AGE;
	logic [INV_W-1:0]    cfg_data = '0;
	logic                sample_valid = 1'b0;
	logic                sample_stall;
	logic [IDX_W-1:0]    entry_index = '0;
	logic [SAMPLE_W-1:0] sample = '0;
	logic                last = 1'b0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	logic [ACC_W-1:0]    accumulated;
	logic [ACC_W-1:0]    residual;
	logic                residual_valid;

	// predictor state
	logic [ACC_W-1:0] pixel_sums [STORE_DEPTH];
	logic [ACC_W-1:0] residual_total;
	logic [INV_W-1:0] inv_age_reg;
	logic [AGE_W-1:0] pass_age_reg;

	sample_item_t sample_queue [$];
	result_t      predicted_results [$];
	int           accepted_items = 0;
	int           mismatches = 0;
	logic         quiet;

	// one long stretch where neither side idles
	assign quiet = accepted_items >= 700 && accepted_items < 1000;

	progressive_pixel_accumulator dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.entry_index    (entry_index),
		.sample         (sample),
		.last           (last),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.accumulated    (accumulated),
		.residual       (residual),
		.residual_valid (residual_valid)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic [ACC_W-1:0] add_clamped(input logic [ACC_W-1:0] a,
		input logic [63:0] b);
		logic [63:0] s;
		s = {32'b0, a} + b;
		return (s > 64'hFFFF_FFFF) ? '1 : s[ACC_W-1:0];
	endfunction

	function automatic void accumulate_sample(input logic [IDX_W-1:0] idx,
		input logic [SAMPLE_W-1:0] smp, input logic lst);
		logic [ACC_W-1:0] old_val;
		logic [ACC_W-1:0] acc;
		logic [63:0]      scaled;
		logic [63:0]      err;
		result_t          r;
		old_val = pixel_sums[idx];
		if (64'(inv_age_reg) * 5 > 64'(FIRST_PASS_LIM)) begin
			// first pass overwrites, error against what was stored
			err = (old_val > smp) ? 64'(old_val) - 64'(smp) : 64'(smp) - 64'(old_val);
			acc = 32'(smp);
		end else begin
			acc = add_clamped(old_val, 64'(smp));
			scaled = (64'(acc) * 64'(inv_age_reg) + 64'(ROUND_HALF)) >> FRAC_W;
			err = (scaled > smp) ? scaled - 64'(smp) : 64'(smp) - scaled;
		end
		if (err > ERR_THRESHOLD)
			residual_total = add_clamped(residual_total, err);
		pixel_sums[idx] = acc;
		r.accumulated = acc;
		if (lst) begin
			r.residual = residual_total / (32'(RES_BIAS) + 32'(pass_age_reg));
			r.residual_valid = 1'b1;
			residual_total = '0;
		end else begin
			r.residual = '0;
			r.residual_valid = 1'b0;
		end
		predicted_results.push_back(r);
	endfunction

	// sender: one item per handshake, random idles between items
	always @(posedge clk) begin
		sample_item_t nxt;
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else if (!sample_valid || !sample_stall) begin
			if (sample_valid) begin
				accumulate_sample(entry_index, sample, last);
				accepted_items++;
			end
			if (sample_queue.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
				nxt = sample_queue.pop_front();
				sample_valid <= 1'b1;
				entry_index <= nxt.idx;
				sample <= nxt.smp;
				last <= nxt.lst;
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		result_stall <= arst_n && !quiet && ($urandom_range(99) < IDLE_PCT);
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (predicted_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result acc=%0d res=%0d res_valid=%0b",
						$time, accumulated, residual, residual_valid);
			end else begin
				want = predicted_results.pop_front();
				if (want.accumulated !== accumulated || want.residual !== residual ||
					want.residual_valid !== residual_valid) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: expected acc=%0d res=%0d res_valid=%0b, got acc=%0d res=%0d res_valid=%0b",
							$time, want.accumulated, want.residual, want.residual_valid,
							accumulated, residual, residual_valid);
				end
			end
		end
	end

	// block until the sender is empty and every predicted result has come back
	task automatic drain();
		@(negedge clk);
		while (sample_queue.size() != 0 || sample_valid || predicted_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_config(input logic [INV_W-1:0] inv, input logic [AGE_W-1:0] age);
		drain();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_INV_AGE;
		cfg_data <= inv;
		@(posedge clk);
		cfg_index <= REG_PASS_AGE;
		// the top data bit is outside the age register and must be dropped
		cfg_data <= {1'($urandom_range(1)), age};
		@(posedge clk);
		cfg_we <= 1'b0;
		inv_age_reg = inv;
		pass_age_reg = age;
		@(negedge clk);
	endtask

	task automatic queue_item(input int idx, input int smp, input logic lst);
		sample_item_t it;
		it.idx = IDX_W'(idx);
		it.smp = SAMPLE_W'(smp);
		it.lst = lst;
		sample_queue.push_back(it);
	endtask

	initial begin
		int random_items;
		int k;
		int i;
		int n;
		int win_start;
		int win_size;
		int passes;
		int age_offset;
		int colour;
		int window_colour [24];
		logic [INV_W-1:0] inv;
		logic [AGE_W-1:0] age;

		for (i = 0; i < STORE_DEPTH; i++)
			pixel_sums[i] = '0;
		residual_total = '0;
		inv_age_reg = INV_W'(INV_AGE_RESET);
		pass_age_reg = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// first pass: overwrite, error against the old entry
		write_config(INV_W'(INV_AGE_RESET), 16'd0);
		queue_item(0, 0, 1'b0);
		queue_item(4095, 65535, 1'b0);
		queue_item(4095, 0, 1'b0);
		queue_item(1, 32, 1'b0);
		queue_item(2, 33, 1'b0);
		queue_item(3, 65535, 1'b1);
		// just at or below 0.6 accumulates; largest divisor
		write_config(17'd39321, 16'hFFFF);
		queue_item(4095, 65535, 1'b0);
		queue_item(0, 65535, 1'b0);
		queue_item(5, 0, 1'b1);
		// just above 0.6 overwrites
		write_config(17'd39322, 16'd1);
		queue_item(4095, 100, 1'b0);
		queue_item(6, 0, 1'b1);
		// zero inverse age: scaled average is zero, error is the sample itself
		write_config(17'd0, 16'd2);
		queue_item(7, 33, 1'b0);
		queue_item(7, 32, 1'b0);
		queue_item(8, 65535, 1'b1);
		// inverse age beyond 1.0, then back-to-back last items, one of them with an empty sum
		write_config(17'h1FFFF, 16'hFFFF);
		queue_item(9, 1234, 1'b0);
		queue_item(10, 0, 1'b1);
		queue_item(11, 0, 1'b1);
		queue_item(12, 65535, 1'b1);

		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			if ($urandom_range(9) < 7) begin
				// progressive render over a window of entries, one pass per setting
				win_start = $urandom_range(STORE_DEPTH - 1);
				win_size = $urandom_range(1, 24);
				passes = $urandom_range(2, 8);
				age_offset = ($urandom_range(3) == 0) ? $urandom_range(65535 - 8) : 0;
				for (i = 0; i < win_size; i++)
					window_colour[i] = $urandom_range(65535);
				for (k = 1; k <= passes; k++) begin
					write_config(INV_W'((65536 + k / 2) / k), AGE_W'(k - 1 + age_offset));
					for (i = 0; i < win_size; i++) begin
						if ($urandom_range(7) == 0)
							colour = $urandom_range(65535);
						else
							colour = window_colour[i] + $urandom_range(160) - 80;
						if (colour < 0)
							colour = 0;
						if (colour > 65535)
							colour = 65535;
						// now and then the last mark is missing or comes early
						queue_item(win_start + i, colour, (i == win_size - 1) ?
							($urandom_range(7) != 0) : ($urandom_range(31) == 0));
						random_items++;
					end
				end
			end else begin
				case ($urandom_range(8))
					0: inv = 17'd0;
					1: inv = 17'd1;
					2: inv = 17'd39321;
					3: inv = 17'd39322;
					4: inv = 17'd65535;
					5: inv = 17'd65536;
					6: inv = 17'd65537;
					7: inv = 17'h1FFFF;
					default: inv = INV_W'($urandom_range(131071));
				endcase
				case ($urandom_range(4))
					0: age = 16'd0;
					1: age = 16'hFFFF;
					default: age = AGE_W'($urandom_range(65535));
				endcase
				write_config(inv, age);
				n = $urandom_range(20, 60);
				win_start = $urandom_range(STORE_DEPTH - 1);
				for (i = 0; i < n; i++) begin
					// half the items revisit a handful of entries
					queue_item(($urandom_range(1) == 0) ? win_start + $urandom_range(7) :
						$urandom_range(STORE_DEPTH - 1), $urandom_range(65535),
						$urandom_range(7) == 0);
					random_items++;
				end
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && predicted_results.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
